// ===== rtl/twsd_pkg.sv =====
// Shared types and constants for the two-wheel straight-drive controller.
// Depends on nothing; every other file in rtl/ imports it.
`timescale 1ns / 1ps

package twsd_pkg;

  // Default fraction width of the duty value
  localparam int DUTY_FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int OPC_W      = 2;
  localparam int SPEED_W    = 11;
  localparam int TSPEED_W   = 10;
  localparam int DELTA_W    = 12;
  localparam int DIST_W     = 24;
  localparam int DREQ_W     = 16;
  localparam int TGT_W      = DREQ_W + 4;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Stop margin taken off the requested distance, in mm
  localparam logic [DREQ_W-1:0] DIST_MARGIN = DREQ_W'(20);

  // Register reset values
  localparam logic [TSPEED_W-1:0] SPEED_RST = TSPEED_W'(300);

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
  localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;
  localparam logic [DIR_W-1:0] DIR_REV  = 2'b11;
  localparam logic [DIR_W-1:0] DIR_NEG2 = 2'b10;

  // Command codes carried in the opcode field
  typedef enum logic [OPC_W-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } opcode_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION = 2'd0,
    CFG_SPEED     = 2'd1,
    CFG_DISTANCE  = 2'd2
  } cfg_reg_t;

  // Stage load strobes handed to the speed-error units
  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } pipe_ctl_t;

endpackage

// ===== rtl/twsd_cmd_if.sv =====
// Command channel: opcode, measured speeds and distance deltas per beat.
// Depends on twsd_pkg for field widths.
`timescale 1ns / 1ps

interface twsd_cmd_if
  import twsd_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [OPC_W-1:0]     opcode;
  logic [SPEED_W-1:0]   left_measured_speed;
  logic [SPEED_W-1:0]   right_measured_speed;
  logic [DELTA_W-1:0]   left_moved_delta;
  logic [DELTA_W-1:0]   right_moved_delta;

  modport source (
    output valid, opcode, left_measured_speed, right_measured_speed,
           left_moved_delta, right_moved_delta,
    input  ready
  );
  modport sink (
    input  valid, opcode, left_measured_speed, right_measured_speed,
           left_moved_delta, right_moved_delta,
    output ready
  );
endinterface

// ===== rtl/twsd_res_if.sv =====
// Result channel: per-wheel drive duty, direction, activity and move done.
// Depends on twsd_pkg for field widths and the default duty width.
`timescale 1ns / 1ps

interface twsd_res_if
  import twsd_pkg::*;
  #(parameter int DUTY_W = DUTY_FRAC_BITS_DEF + 1)
  ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] left_drive;
  logic [DUTY_W-1:0] right_drive;
  logic [DIR_W-1:0]  left_direction;
  logic [DIR_W-1:0]  right_direction;
  logic              left_active;
  logic              right_active;
  logic              move_done;

  modport source (
    output valid, left_drive, right_drive, left_direction, right_direction,
           left_active, right_active, move_done,
    input  ready
  );
  modport sink (
    input  valid, left_drive, right_drive, left_direction, right_direction,
           left_active, right_active, move_done,
    output ready
  );
endinterface

// ===== rtl/two_wheel_straight_drive_controller.sv =====
// Two-wheel straight-drive controller: top level.
// Depends on twsd_pkg, twsd_cmd_if, twsd_res_if and twsd_err_step.
//
// Usage
//   cmd carries one beat per command: tick (speeds and distance deltas),
//   start move or stop. res returns exactly one beat per command with both
//   wheel duties, directions, activity flags and a move-done pulse. The user
//   writes registers (direction, target speed, distance) via cfg_we /
//   cfg_index / cfg_data while no command is in flight; nothing enforces it.
// Timing
//   Three-stage pipeline: input stage, error-step stage, result register.
//   A command accepted into the input stage passes the error-step stage
//   and the result register before it shows on res. One command per cycle
//   sustained while res is ready; the duty and distance state is updated in
//   the same cycle as a command enters the result register.
// Reset
//   rst (synchronous) empties the pipeline, stops both wheels, clears the
//   distance counters, sets both duties to one half and the registers to
//   forward, 300 mm/s and zero distance.
// Back-pressure
//   Each stage holds while the one after it is full; cmd.ready stays high
//   while the input stage has room, even when res is stalled.
`timescale 1ns / 1ps

module two_wheel_straight_drive_controller
  import twsd_pkg::*;
  #(parameter int DUTY_FRAC_BITS = DUTY_FRAC_BITS_DEF)
  (
  input  logic                  clk,
  input  logic                  rst,
  twsd_cmd_if.sink              cmd,
  twsd_res_if.source            res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DUTY_W = DUTY_FRAC_BITS + 1;
  localparam int STEP_W = DUTY_FRAC_BITS + 2;
  localparam int ACC_W  = DUTY_FRAC_BITS + 4;
  localparam logic [DUTY_W-1:0] DUTY_ONE  = DUTY_W'(1) << DUTY_FRAC_BITS;
  localparam logic [DUTY_W-1:0] DUTY_HALF = DUTY_W'(1) << (DUTY_FRAC_BITS - 1);
  localparam int BAL_STEP = (2 ** DUTY_FRAC_BITS + 50) / 100;
  localparam logic signed [ACC_W-1:0] ACC_ONE = signed'(ACC_W'(DUTY_ONE));
  localparam logic signed [ACC_W-1:0] ACC_BAL = signed'(ACC_W'(BAL_STEP));

  // Configuration registers
  logic [DIR_W-1:0]    cfg_dir;
  logic [TSPEED_W-1:0] cfg_speed;
  logic [DREQ_W-1:0]   cfg_dist;

  // Pipeline control
  logic      s1_valid, s2_valid, out_valid;
  logic      s1_ready, s2_ready, out_load;
  pipe_ctl_t pipe_ctl;

  // Stage payloads
  logic [OPC_W-1:0]   s1_opcode, s2_opcode;
  logic [DELTA_W-1:0] s1_ldel, s1_rdel, s2_ldel, s2_rdel;
  logic               s1_l_faster, s1_r_faster, s2_l_faster, s2_r_faster;
  logic [STEP_W-1:0]  l_step, r_step;
  logic               l_step_neg, r_step_neg;

  // Controller state
  logic [DUTY_W-1:0] left_duty, right_duty;
  logic              left_running, right_running;
  logic [DIR_W-1:0]  dir_state;
  logic [DIST_W-1:0] left_distance, right_distance;

  logic [DUTY_W-1:0] left_duty_next, right_duty_next;
  logic              left_running_next, right_running_next;
  logic [DIR_W-1:0]  dir_state_next;
  logic [DIST_W-1:0] left_distance_next, right_distance_next;
  logic              done_next;

  logic [TGT_W-1:0]        target;
  logic [DIST_W:0]         l_sum_w, r_sum_w;
  logic [DIST_W-1:0]       l_sum, r_sum;
  logic                    l_run_t, r_run_t;
  logic signed [ACC_W-1:0] l_acc, r_acc;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_dir   <= DIR_FWD;
      cfg_speed <= SPEED_RST;
      cfg_dist  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIRECTION: cfg_dir <= (cfg_data[DIR_W-1:0] == DIR_NEG2) ? DIR_REV
                                                                   : cfg_data[DIR_W-1:0];
        CFG_SPEED:     cfg_speed <= cfg_data[TSPEED_W-1:0];
        CFG_DISTANCE:  cfg_dist  <= cfg_data[DREQ_W-1:0];
        default:       ;
      endcase
    end
  end

  // Handshake chain, each stage fills when it is empty or drains
  always_comb begin
    out_load = s2_valid && (!out_valid || res.ready);
    s2_ready = !s2_valid || !out_valid || res.ready;
    s1_ready = !s1_valid || s2_ready;
    pipe_ctl.s1_load = cmd.valid && s1_ready;
    pipe_ctl.s2_load = s1_valid && s2_ready;
  end

  assign cmd.ready = s1_ready;
  assign res.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= cmd.valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (!out_valid || res.ready) out_valid <= s2_valid;
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (pipe_ctl.s1_load) begin
      s1_opcode   <= cmd.opcode;
      s1_ldel     <= cmd.left_moved_delta;
      s1_rdel     <= cmd.right_moved_delta;
      s1_l_faster <= cmd.left_measured_speed > cmd.right_measured_speed;
      s1_r_faster <= cmd.right_measured_speed > cmd.left_measured_speed;
    end
  end

  // Error-step stage
  always_ff @(posedge clk) begin
    if (pipe_ctl.s2_load) begin
      s2_opcode   <= s1_opcode;
      s2_ldel     <= s1_ldel;
      s2_rdel     <= s1_rdel;
      s2_l_faster <= s1_l_faster;
      s2_r_faster <= s1_r_faster;
    end
  end

  twsd_err_step #(.DUTY_FRAC_BITS(DUTY_FRAC_BITS)) u_left_step (
    .clk          (clk),
    .ctl          (pipe_ctl),
    .speed        (cmd.left_measured_speed),
    .target_speed (cfg_speed),
    .step         (l_step),
    .step_neg     (l_step_neg)
  );

  twsd_err_step #(.DUTY_FRAC_BITS(DUTY_FRAC_BITS)) u_right_step (
    .clk          (clk),
    .ctl          (pipe_ctl),
    .speed        (cmd.right_measured_speed),
    .target_speed (cfg_speed),
    .step         (r_step),
    .step_neg     (r_step_neg)
  );

  // Stop target in 1/16 mm
  always_comb begin
    target = (cfg_dist > DIST_MARGIN) ? {cfg_dist - DIST_MARGIN, 4'b0000} : '0;
  end

  // Saturating distance accumulation
  always_comb begin
    l_sum_w = {1'b0, left_distance} + (DIST_W+1)'(s2_ldel);
    r_sum_w = {1'b0, right_distance} + (DIST_W+1)'(s2_rdel);
    l_sum   = l_sum_w[DIST_W] ? '1 : l_sum_w[DIST_W-1:0];
    r_sum   = r_sum_w[DIST_W] ? '1 : r_sum_w[DIST_W-1:0];
  end

  // State update for the command leaving the error-step stage
  always_comb begin
    left_duty_next      = left_duty;
    right_duty_next     = right_duty;
    left_running_next   = left_running;
    right_running_next  = right_running;
    dir_state_next      = dir_state;
    left_distance_next  = left_distance;
    right_distance_next = right_distance;
    done_next           = 1'b0;
    l_run_t             = left_running && !(l_sum > DIST_W'(target));
    r_run_t             = right_running && !(r_sum > DIST_W'(target));
    l_acc               = signed'(ACC_W'(left_duty));
    r_acc               = signed'(ACC_W'(right_duty));

    case (s2_opcode)
      OP_START: begin
        left_distance_next  = '0;
        right_distance_next = '0;
        if (target == '0) begin
          left_running_next  = 1'b0;
          right_running_next = 1'b0;
          dir_state_next     = DIR_NONE;
          done_next          = 1'b1;
        end else begin
          left_running_next  = 1'b1;
          right_running_next = 1'b1;
          dir_state_next     = (cfg_speed != '0) ? cfg_dir : DIR_NONE;
        end
      end
      OP_STOP: begin
        left_running_next  = 1'b0;
        right_running_next = 1'b0;
        dir_state_next     = DIR_NONE;
      end
      OP_TICK: begin
        if (left_running || right_running) begin
          left_distance_next  = l_sum;
          right_distance_next = r_sum;
          left_running_next   = l_run_t;
          right_running_next  = r_run_t;
          // Move complete once the summed distance reaches twice the target
          if (({1'b0, l_sum} + {1'b0, r_sum}) >= (DIST_W+1)'({target, 1'b0})) begin
            left_running_next  = 1'b0;
            right_running_next = 1'b0;
            dir_state_next     = DIR_NONE;
            done_next          = 1'b1;
          end
          // Speed-error trim, then balance the faster wheel down
          if (left_running_next) begin
            l_acc = l_step_neg ? l_acc + signed'(ACC_W'(l_step))
                               : l_acc - signed'(ACC_W'(l_step));
          end
          if (right_running_next) begin
            r_acc = r_step_neg ? r_acc + signed'(ACC_W'(r_step))
                               : r_acc - signed'(ACC_W'(r_step));
          end
          if (left_running_next && right_running_next) begin
            if (s2_l_faster)      l_acc = l_acc - ACC_BAL;
            else if (s2_r_faster) r_acc = r_acc - ACC_BAL;
          end
          // Clamp to 0..1
          if (l_acc[ACC_W-1])     left_duty_next = '0;
          else if (l_acc > ACC_ONE) left_duty_next = DUTY_ONE;
          else                    left_duty_next = DUTY_W'(l_acc);
          if (r_acc[ACC_W-1])     right_duty_next = '0;
          else if (r_acc > ACC_ONE) right_duty_next = DUTY_ONE;
          else                    right_duty_next = DUTY_W'(r_acc);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_duty      <= DUTY_HALF;
      right_duty     <= DUTY_HALF;
      left_running   <= 1'b0;
      right_running  <= 1'b0;
      dir_state      <= DIR_NONE;
      left_distance  <= '0;
      right_distance <= '0;
    end else if (out_load) begin
      left_duty      <= left_duty_next;
      right_duty     <= right_duty_next;
      left_running   <= left_running_next;
      right_running  <= right_running_next;
      dir_state      <= dir_state_next;
      left_distance  <= left_distance_next;
      right_distance <= right_distance_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      res.left_drive      <= left_running_next ? left_duty_next : '0;
      res.right_drive     <= right_running_next ? right_duty_next : '0;
      res.left_direction  <= left_running_next ? dir_state_next : DIR_NONE;
      res.right_direction <= right_running_next ? dir_state_next : DIR_NONE;
      res.left_active     <= left_running_next;
      res.right_active    <= right_running_next;
      res.move_done       <= done_next;
    end
  end

endmodule

// ===== rtl/twsd_err_step.sv =====
// Speed-error duty step for one wheel: |speed - target| * 2^F / 1000,
// rounded half away from zero, over two registered stages. Uses twsd_pkg.
`timescale 1ns / 1ps

module twsd_err_step
  import twsd_pkg::*;
  #(parameter int DUTY_FRAC_BITS = DUTY_FRAC_BITS_DEF)
  (
  input  logic                          clk,
  input  pipe_ctl_t                     ctl,
  input  logic [SPEED_W-1:0]            speed,
  input  logic [TSPEED_W-1:0]           target_speed,
  output logic [DUTY_FRAC_BITS+1:0]     step,
  output logic                          step_neg
);

  localparam int STEP_W = DUTY_FRAC_BITS + 2;
  // (e*2^F + 500) / 1000 == (e*2^(F-3) + 62) / 125, as 2^F is a multiple of 8
  localparam int PRE_SCALE   = 2 ** (DUTY_FRAC_BITS - 3);
  localparam int DIV_BY      = 125;
  localparam int ROUND_OFS   = 62;
  localparam int PRE_QUOT    = PRE_SCALE / DIV_BY;
  localparam int PRE_REM     = PRE_SCALE % DIV_BY;
  // Remainder numerator stays below 2^18; reciprocal exact with 25 shift bits
  localparam int REM_W       = 18;
  localparam int RECIP_SHIFT = 25;
  localparam int RECIP       = (2 ** RECIP_SHIFT + DIV_BY - 1) / DIV_BY;
  localparam int PROD_W      = REM_W + RECIP_SHIFT - 6;

  logic                 err_neg;
  logic [SPEED_W-1:0]   err_mag;
  logic [SPEED_W-1:0]   s1_mag;
  logic                 s1_neg;
  logic [REM_W-1:0]     s1_rem_num;
  logic [PROD_W-1:0]    rem_prod;
  logic [STEP_W-1:0]    quot_part;
  logic [STEP_W-1:0]    step_next;

  // Magnitude and sign of the speed error
  always_comb begin
    err_neg = speed < SPEED_W'(target_speed);
    err_mag = err_neg ? SPEED_W'(target_speed) - speed
                      : speed - SPEED_W'(target_speed);
  end

  // Stage 1: error split into whole multiples of 125 and a remainder numerator
  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      s1_mag     <= err_mag;
      s1_neg     <= err_neg;
      s1_rem_num <= REM_W'(err_mag) * REM_W'(PRE_REM) + REM_W'(ROUND_OFS);
    end
  end

  // Stage 2: reciprocal divide of the remainder plus the whole part
  always_comb begin
    rem_prod  = PROD_W'(s1_rem_num) * PROD_W'(RECIP);
    quot_part = STEP_W'(s1_mag) * STEP_W'(PRE_QUOT);
    step_next = quot_part + STEP_W'(rem_prod[RECIP_SHIFT +: SPEED_W]);
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      step     <= step_next;
      step_neg <= s1_neg;
    end
  end

endmodule

// ===== rtl/twsd_checker.sv =====
// Port-level checks for the straight-drive controller, bound to the top.
// Depends on twsd_pkg and two_wheel_straight_drive_controller.
`timescale 1ns / 1ps

module twsd_checker
  import twsd_pkg::*;
  #(parameter int DUTY_FRAC_BITS = DUTY_FRAC_BITS_DEF)
  (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [DUTY_FRAC_BITS:0]   left_drive,
  input logic [DUTY_FRAC_BITS:0]   right_drive,
  input logic [DIR_W-1:0]          left_direction,
  input logic                      left_active,
  input logic                      right_active,
  input logic                      move_done
);

  localparam logic [DUTY_FRAC_BITS:0] DUTY_ONE = (DUTY_FRAC_BITS+1)'(1) << DUTY_FRAC_BITS;

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present after reset");

  // A stalled result beat stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A finished move leaves both wheels stopped
  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && move_done |-> !left_active && !right_active)
    else $error("move done with a wheel still active");

  // A stopped left wheel shows no drive and no direction
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !left_active |-> left_drive == '0 && left_direction == DIR_NONE)
    else $error("stopped left wheel still driven");

  // Duty never exceeds full scale
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> left_drive <= DUTY_ONE && right_drive <= DUTY_ONE)
    else $error("drive duty above full scale");

endmodule

bind two_wheel_straight_drive_controller twsd_checker
  #(.DUTY_FRAC_BITS(DUTY_FRAC_BITS)) u_twsd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (res.valid),
  .out_ready      (res.ready),
  .left_drive     (res.left_drive),
  .right_drive    (res.right_drive),
  .left_direction (res.left_direction),
  .left_active    (res.left_active),
  .right_active   (res.right_active),
  .move_done      (res.move_done)
);

// ===== tb/tb_two_wheel_straight_drive_controller.sv =====
// Self-checking testbench for the two-wheel straight-drive controller.
// Depends on twsd_pkg, twsd_cmd_if, twsd_res_if and the controller RTL.
`timescale 1ns / 1ps

module tb_two_wheel_straight_drive_controller;
  import twsd_pkg::*;

  localparam int DUTY_W         = DUTY_FRAC_BITS_DEF + 1;
  localparam int DUTY_FULL      = 1 << DUTY_FRAC_BITS_DEF;
  localparam int DUTY_HALF      = DUTY_FULL / 2;
  localparam int BAL_STEP       = (DUTY_FULL + 50) / 100;
  localparam int ERR_SCALE      = 1000;
  localparam int RX_HOLD_CYCLES = 64;
  localparam int WDOG_LIMIT     = 500;
  localparam int PHASES         = 28;
  localparam int QUIET_PHASE    = 24;
  localparam int HOLD_PHASE     = 5;
  localparam int PHASE_BEATS    = 50;
  localparam logic [OPC_W-1:0]  OP_UNUSED = 2'd3;
  localparam logic [DIST_W-1:0] DIST_SAT  = '1;

  typedef struct packed {
    logic [OPC_W-1:0]   opcode;
    logic [SPEED_W-1:0] left_measured_speed;
    logic [SPEED_W-1:0] right_measured_speed;
    logic [DELTA_W-1:0] left_moved_delta;
    logic [DELTA_W-1:0] right_moved_delta;
  } cmd_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_drive;
    logic [DUTY_W-1:0] right_drive;
    logic [DIR_W-1:0]  left_direction;
    logic [DIR_W-1:0]  right_direction;
    logic              left_active;
    logic              right_active;
    logic              move_done;
  } drive_t;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    cmd_t                  beat;
    logic                  known;
    drive_t                res;
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] data;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  twsd_cmd_if cmd_ch ();
  twsd_res_if res_ch ();

  two_wheel_straight_drive_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rows typed-in expectation travels with the beat
  logic   row_known;
  drive_t row_exp;

  // Predictor state: registers, duties, run flags, directions, distances
  logic [DIR_W-1:0]    reg_dir;
  logic [TSPEED_W-1:0] reg_speed;
  logic [DREQ_W-1:0]   reg_dist;
  logic [DUTY_W-1:0]   l_duty, r_duty;
  logic                l_run, r_run;
  logic [DIR_W-1:0]    l_dir, r_dir;
  logic [DIST_W-1:0]   l_dist, r_dist;

  drive_t due_drive[$];
  row_t   plan[$];

  // Stimulus-side copies of the registers, used to size random beats
  logic [TSPEED_W-1:0] drv_speed = SPEED_RST;
  logic [DREQ_W-1:0]   drv_dist  = '0;

  logic tx_gaps_en  = 1'b1;
  logic rx_stall_en = 1'b1;
  logic rx_hold_req = 1'b0;

  int fails    = 0;
  int n_cmd    = 0;
  int n_res    = 0;
  int n_moves  = 0;
  int n_writes = 0;
  int idle_cycles = 0;

  // ---------------------------------------------------------------- predictor

  function automatic int err_step(int e);
    int m;
    m = (e < 0 ? -e : e) << DUTY_FRAC_BITS_DEF;
    m = (m + ERR_SCALE / 2) / ERR_SCALE;
    return e < 0 ? -m : m;
  endfunction

  function automatic logic [DUTY_W-1:0] clamp_duty(int v);
    if (v < 0) return '0;
    if (v > DUTY_FULL) return DUTY_W'(DUTY_FULL);
    return DUTY_W'(v);
  endfunction

  function automatic logic [DIST_W-1:0] sat_dist(logic [DIST_W-1:0] a,
                                                 logic [DELTA_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + (DIST_W + 1)'(b);
    return s[DIST_W] ? DIST_SAT : s[DIST_W-1:0];
  endfunction

  function automatic void halt_wheels();
    l_run = 1'b0;
    r_run = 1'b0;
    l_dir = DIR_NONE;
    r_dir = DIR_NONE;
  endfunction

  // Applies one command beat to the state and returns the drive it produces
  function automatic drive_t advance_drive(cmd_t c);
    drive_t           r;
    logic [TGT_W-1:0] tgt;
    logic [DIR_W-1:0] d;
    logic [DIST_W:0]  s;
    int lerr, rerr, ld, rd;
    r = '0;
    tgt = (reg_dist > DIST_MARGIN) ? {reg_dist - DIST_MARGIN, 4'b0000} : '0;
    case (c.opcode)
      OP_START: begin
        d = (reg_speed != 0) ? reg_dir : DIR_NONE;
        l_dist = '0;
        r_dist = '0;
        l_run = 1'b1;
        r_run = 1'b1;
        l_dir = d;
        r_dir = d;
        // nothing to travel: the move ends on the start beat
        if (tgt == 0) begin
          halt_wheels();
          r.move_done = 1'b1;
        end
      end
      OP_STOP: halt_wheels();
      OP_TICK: begin
        if (l_run || r_run) begin
          // distances first, then stop checks, then completion
          l_dist = sat_dist(l_dist, c.left_moved_delta);
          r_dist = sat_dist(r_dist, c.right_moved_delta);
          if (l_run && l_dist > tgt) l_run = 1'b0;
          if (r_run && r_dist > tgt) r_run = 1'b0;
          s = {1'b0, l_dist} + {1'b0, r_dist};
          if (s >= {tgt, 1'b0}) begin
            halt_wheels();
            r.move_done = 1'b1;
          end
          // speed trim, plus balance penalty on the faster wheel
          if (l_run || r_run) begin
            lerr = int'(c.left_measured_speed) - int'(reg_speed);
            rerr = int'(c.right_measured_speed) - int'(reg_speed);
            ld = int'(l_duty);
            rd = int'(r_duty);
            if (l_run) ld -= err_step(lerr);
            if (r_run) rd -= err_step(rerr);
            if (l_run && r_run) begin
              if (lerr > rerr) ld -= BAL_STEP;
              else if (rerr > lerr) rd -= BAL_STEP;
            end
            l_duty = clamp_duty(ld);
            r_duty = clamp_duty(rd);
          end
        end
      end
      default: ;  // unused opcode: no effect
    endcase
    r.left_drive      = l_run ? l_duty : '0;
    r.right_drive     = r_run ? r_duty : '0;
    r.left_direction  = l_run ? l_dir : DIR_NONE;
    r.right_direction = r_run ? r_dir : DIR_NONE;
    r.left_active     = l_run;
    r.right_active    = r_run;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic check_drive(drive_t e, drive_t g);
    if (g.left_drive !== e.left_drive) begin
      $error("left_drive: expected %0d, got %0d", e.left_drive, g.left_drive);
      fails++;
    end
    if (g.right_drive !== e.right_drive) begin
      $error("right_drive: expected %0d, got %0d", e.right_drive, g.right_drive);
      fails++;
    end
    if (g.left_direction !== e.left_direction) begin
      $error("left_direction: expected %b, got %b", e.left_direction, g.left_direction);
      fails++;
    end
    if (g.right_direction !== e.right_direction) begin
      $error("right_direction: expected %b, got %b", e.right_direction,
             g.right_direction);
      fails++;
    end
    if (g.left_active !== e.left_active) begin
      $error("left_active: expected %b, got %b", e.left_active, g.left_active);
      fails++;
    end
    if (g.right_active !== e.right_active) begin
      $error("right_active: expected %b, got %b", e.right_active, g.right_active);
      fails++;
    end
    if (g.move_done !== e.move_done) begin
      $error("move_done: expected %b, got %b", e.move_done, g.move_done);
      fails++;
    end
  endtask

  // Sample both channels and the register port; keep a stall watchdog
  always @(posedge clk) begin : watch
    cmd_t   c;
    drive_t want, got;
    logic   cmd_acc, res_acc;
    if (rst) begin
      reg_dir   = DIR_FWD;
      reg_speed = SPEED_RST;
      reg_dist  = '0;
      l_duty    = DUTY_W'(DUTY_HALF);
      r_duty    = DUTY_W'(DUTY_HALF);
      halt_wheels();
      l_dist    = '0;
      r_dist    = '0;
      idle_cycles = 0;
    end else begin
      cmd_acc = cmd_ch.valid && cmd_ch.ready;
      res_acc = res_ch.valid && res_ch.ready;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIRECTION: begin
            case (cfg_data[DIR_W-1:0])
              DIR_NONE: reg_dir = DIR_NONE;
              DIR_FWD:  reg_dir = DIR_FWD;
              default:  reg_dir = DIR_REV;  // -2 saturates to -1
            endcase
          end
          CFG_SPEED:    reg_speed = cfg_data[TSPEED_W-1:0];
          CFG_DISTANCE: reg_dist  = cfg_data[DREQ_W-1:0];
          default: ;
        endcase
      end
      if (cmd_acc) begin
        c.opcode               = cmd_ch.opcode;
        c.left_measured_speed  = cmd_ch.left_measured_speed;
        c.right_measured_speed = cmd_ch.right_measured_speed;
        c.left_moved_delta     = cmd_ch.left_moved_delta;
        c.right_moved_delta    = cmd_ch.right_moved_delta;
        want = advance_drive(c);
        if (row_known) want = row_exp;
        due_drive.push_back(want);
        n_cmd++;
        if (want.move_done) n_moves++;
      end
      if (res_acc) begin
        got.left_drive      = res_ch.left_drive;
        got.right_drive     = res_ch.right_drive;
        got.left_direction  = res_ch.left_direction;
        got.right_direction = res_ch.right_direction;
        got.left_active     = res_ch.left_active;
        got.right_active    = res_ch.right_active;
        got.move_done       = res_ch.move_done;
        n_res++;
        if (due_drive.size() == 0) begin
          $error("result beat arrived with no command outstanding");
          fails++;
        end else begin
          check_drive(due_drive.pop_front(), got);
        end
      end
      idle_cycles = (cmd_acc || res_acc) ? 0 : idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 idle_cycles, due_drive.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- result sink

  initial begin : sink
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        // long hold so the pipeline fills and back-pressures the input
        rx_hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else if (rx_stall_en && $urandom_range(0, 7) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic drive_t drive_of(int ldr, int rdr, logic [DIR_W-1:0] ldi,
                                      logic [DIR_W-1:0] rdi, logic la, logic ra,
                                      logic dn);
    drive_t r;
    r.left_drive      = DUTY_W'(ldr);
    r.right_drive     = DUTY_W'(rdr);
    r.left_direction  = ldi;
    r.right_direction = rdi;
    r.left_active     = la;
    r.right_active    = ra;
    r.move_done       = dn;
    return r;
  endfunction

  task automatic add_beat(logic [OPC_W-1:0] op, int ls, int rs, int ld, int rd,
                          logic known = 1'b0, drive_t e = '0);
    row_t w;
    w = '0;
    w.kind = ROW_BEAT;
    w.beat.opcode               = op;
    w.beat.left_measured_speed  = SPEED_W'(ls);
    w.beat.right_measured_speed = SPEED_W'(rs);
    w.beat.left_moved_delta     = DELTA_W'(ld);
    w.beat.right_moved_delta    = DELTA_W'(rd);
    w.known = known;
    w.res   = e;
    plan.push_back(w);
  endtask

  task automatic add_reg(cfg_reg_t idx, int data);
    row_t w;
    w = '0;
    w.kind = ROW_REG;
    w.idx  = idx;
    w.data = CFG_DATA_W'(data);
    plan.push_back(w);
  endtask

  // Offer one command beat, with an optional gap first
  task automatic send_beat(cmd_t b, logic known, drive_t e);
    if (tx_gaps_en && $urandom_range(0, 5) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cmd_ch.valid                <= 1'b1;
    cmd_ch.opcode               <= b.opcode;
    cmd_ch.left_measured_speed  <= b.left_measured_speed;
    cmd_ch.right_measured_speed <= b.right_measured_speed;
    cmd_ch.left_moved_delta     <= b.left_moved_delta;
    cmd_ch.right_moved_delta    <= b.right_moved_delta;
    row_known                   <= known;
    row_exp                     <= e;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Stop offering and wait until every outstanding result is back
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (due_drive.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] w);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_writes++;
    if (idx == CFG_SPEED) drv_speed = w[TSPEED_W-1:0];
    if (idx == CFG_DISTANCE) drv_dist = w[DREQ_W-1:0];
  endtask

  function automatic int near_speed();
    int v;
    v = int'(drv_speed) + int'($urandom_range(0, 80)) - 40;
    return v < 0 ? 0 : v;
  endfunction

  function automatic int random_delta(int reach);
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 4095);
      1:       return 0;
      default: return $urandom_range(0, reach);
    endcase
  endfunction

  // Mostly ticks sized to finish a move in a few beats, some noise
  function automatic cmd_t random_beat();
    cmd_t c;
    int pick, tgt, reach;
    pick = $urandom_range(0, 99);
    if (pick < 6)       c.opcode = OP_START;
    else if (pick < 9)  c.opcode = OP_STOP;
    else if (pick < 11) c.opcode = OP_UNUSED;
    else                c.opcode = OP_TICK;
    c.left_measured_speed  = SPEED_W'(($urandom_range(0, 3) == 0) ?
                                      $urandom_range(0, 2047) : near_speed());
    c.right_measured_speed = SPEED_W'(($urandom_range(0, 3) == 0) ?
                                      $urandom_range(0, 2047) : near_speed());
    if ($urandom_range(0, 7) == 0) c.right_measured_speed = c.left_measured_speed;
    tgt = (drv_dist > DIST_MARGIN) ? (int'(drv_dist) - 20) * 16 : 0;
    reach = tgt / 3 + 8;
    if (reach > 4095) reach = 4095;
    c.left_moved_delta  = DELTA_W'(random_delta(reach));
    c.right_moved_delta = DELTA_W'(random_delta(reach));
    return c;
  endfunction

  initial begin : stim
    drive_t zero_out, done_out;
    row_t   rw;
    logic [CFG_DATA_W-1:0] w;
    int ph, k;

    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode               = '0;
    cmd_ch.left_measured_speed  = '0;
    cmd_ch.right_measured_speed = '0;
    cmd_ch.left_moved_delta     = '0;
    cmd_ch.right_moved_delta    = '0;
    row_known = 1'b0;
    row_exp   = '0;

    zero_out = drive_of(0, 0, DIR_NONE, DIR_NONE, 1'b0, 1'b0, 1'b0);
    done_out = drive_of(0, 0, DIR_NONE, DIR_NONE, 1'b0, 1'b0, 1'b1);

    // Directed: idle behaviour straight out of reset, zero target
    add_beat(OP_TICK, 2047, 2047, 4095, 4095, 1'b1, zero_out);
    add_beat(OP_UNUSED, 0, 0, 0, 0, 1'b1, zero_out);
    add_beat(OP_START, 0, 0, 0, 0, 1'b1, done_out);
    add_beat(OP_STOP, 0, 0, 0, 0, 1'b1, zero_out);
    // 100 mm move: trims both ways, one wheel stops early, then completion
    add_reg(CFG_DISTANCE, 100);
    add_beat(OP_START, 0, 0, 0, 0, 1'b1,
             drive_of(DUTY_HALF, DUTY_HALF, DIR_FWD, DIR_FWD, 1'b1, 1'b1, 1'b0));
    add_beat(OP_TICK, 300, 300, 100, 100);
    add_beat(OP_TICK, 2047, 0, 0, 0);
    add_beat(OP_TICK, 0, 2047, 0, 0);
    add_beat(OP_TICK, 300, 310, 1200, 0);
    add_beat(OP_TICK, 300, 300, 0, 4095, 1'b1, done_out);
    add_beat(OP_TICK, 1, 2, 5, 5, 1'b1, zero_out);
    // reverse with zero speed: wheels run with no direction
    add_reg(CFG_DIRECTION, 3);
    add_reg(CFG_SPEED, 0);
    add_beat(OP_START, 0, 0, 0, 0);
    add_beat(OP_TICK, 2047, 2047, 10, 10);
    add_beat(OP_STOP, 0, 0, 0, 0, 1'b1, zero_out);
    // -2 direction pattern, top speed, longest distance: duty clamps
    add_reg(CFG_DIRECTION, 16'hFFFE);
    add_reg(CFG_SPEED, 16'hFFFF);
    add_reg(CFG_DISTANCE, 65535);
    add_beat(OP_START, 0, 0, 0, 0);
    add_beat(OP_TICK, 0, 0, 4095, 4095, 1'b1,
             drive_of(DUTY_FULL, DUTY_FULL, DIR_REV, DIR_REV, 1'b1, 1'b1, 1'b0));
    add_beat(OP_TICK, 2047, 2047, 4095, 4095, 1'b1,
             drive_of(0, 0, DIR_REV, DIR_REV, 1'b1, 1'b1, 1'b0));
    add_beat(OP_STOP, 0, 0, 0, 0, 1'b1, zero_out);
    // 1 mm target: completion exactly on the sum, and after a lone stop
    add_reg(CFG_DIRECTION, 1);
    add_reg(CFG_DISTANCE, 21);
    add_beat(OP_START, 0, 0, 0, 0);
    add_beat(OP_TICK, 300, 300, 16, 16, 1'b1, done_out);
    add_beat(OP_START, 0, 0, 0, 0);
    add_beat(OP_TICK, 300, 300, 17, 0);
    add_beat(OP_TICK, 300, 300, 0, 15, 1'b1, done_out);
    // margin swallows the whole request
    add_reg(CFG_DISTANCE, 20);
    add_beat(OP_START, 0, 0, 0, 0, 1'b1, done_out);
    add_beat(OP_TICK, 700, 9, 4095, 4095, 1'b1, zero_out);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < plan.size(); k++) begin
      rw = plan[k];
      if (rw.kind == ROW_REG) write_reg(rw.idx, rw.data);
      else send_beat(rw.beat, rw.known, rw.res);
    end

    // Random phases, each retuning some registers from idle
    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      tx_gaps_en  = (ph < QUIET_PHASE) && (ph != HOLD_PHASE);
      rx_stall_en = (ph < QUIET_PHASE);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 7))
          0:       w = CFG_DATA_W'(DIR_NONE);
          1:       w = CFG_DATA_W'(DIR_NEG2);
          2, 3:    w = CFG_DATA_W'(DIR_REV);
          default: w = CFG_DATA_W'(DIR_FWD);
        endcase
        write_reg(CFG_DIRECTION, w);
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0:       w = '0;
          1:       w = 16'd1023;
          default: w = CFG_DATA_W'($urandom_range(50, 600));
        endcase
        write_reg(CFG_SPEED, w);
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 9))
          0:       w = CFG_DATA_W'($urandom_range(0, 20));
          1:       w = 16'd21;
          2:       w = 16'hFFFF;
          3:       w = CFG_DATA_W'($urandom_range(401, 65535));
          default: w = CFG_DATA_W'($urandom_range(22, 400));
        endcase
        write_reg(CFG_DISTANCE, w);
      end
      if (ph == HOLD_PHASE) rx_hold_req = 1'b1;
      for (k = 0; k < PHASE_BEATS; k++) send_beat(random_beat(), 1'b0, '0);
    end

    drain();
    repeat (8) @(posedge clk);
    $display("summary: %0d commands sent, %0d results checked, %0d moves finished,",
             n_cmd, n_res, n_moves);
    $display("summary: %0d register writes across %0d random phases",
             n_writes, PHASES);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/twsd_pkg.sv
rtl/twsd_cmd_if.sv
rtl/twsd_res_if.sv
rtl/twsd_err_step.sv
rtl/two_wheel_straight_drive_controller.sv
rtl/twsd_checker.sv
tb/tb_two_wheel_straight_drive_controller.sv
